/* hw/rtl/node_table_with_aging_top_macros.svh */
// Assertion macros shared by the node table checker.
`ifndef NODE_TABLE_WITH_AGING_TOP_MACROS_SVH
`define NODE_TABLE_WITH_AGING_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NTA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("node table check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define NTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("node table check failed");

`endif

/* hw/rtl/nta_pkg.sv */
// Package with the types, codes and sizes of the node table.
package nta_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_PURGE  = 2'd3;

    localparam logic [2:0] ST_UPDATED      = 3'd0;
    localparam logic [2:0] ST_INSERTED     = 3'd1;
    localparam logic [2:0] ST_FOUND        = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd3;
    localparam logic [2:0] ST_FULL_OR_DONE = 3'd4;

    localparam logic [15:0] TIMEOUT_RESET = 16'd15;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] ip_address;
        logic [15:0] port;
        logic [15:0] cpu_available;
        logic [15:0] memory_available;
        logic [15:0] gpu_available;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] port_value;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic in_tick;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

/* hw/rtl/nta_ctrl.sv */
// Controller state machine that sequences accept, table walk and commit.
module nta_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  nta_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output nta_pkg::t_cmd o_cmd
);

    nta_pkg::t_state r_state;
    nta_pkg::t_state n_state;
    logic            w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nta_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nta_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = i_sts.in_tick ? nta_pkg::S_COMMIT : nta_pkg::S_SCAN;
                end
            end
            nta_pkg::S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = nta_pkg::S_DRAIN;
                end
            end
            nta_pkg::S_DRAIN:  n_state = nta_pkg::S_COMMIT;
            nta_pkg::S_COMMIT: n_state = nta_pkg::S_IDLE;
            default:           n_state = nta_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            nta_pkg::S_IDLE:   o_in_ready   = i_sts.out_free;
            nta_pkg::S_SCAN:   o_cmd.scan   = 1'b1;
            nta_pkg::S_DRAIN:  o_cmd.scan   = 1'b0;
            nta_pkg::S_COMMIT: o_cmd.commit = 1'b1;
            default:           o_in_ready   = 1'b0;
        endcase
        o_cmd.load = i_in_valid && o_in_ready;
    end

endmodule

/* hw/rtl/nta_dpath.sv */
// Datapath: entry memories, valid bits, walk counter, compare and result register.
module nta_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nta_pkg::t_cmd     i_cmd,
    output nta_pkg::t_sts     o_sts,
    input  nta_pkg::t_in_item i_in_data,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output nta_pkg::t_out_item o_out_data
);

    logic [31:0] r_key_mem  [nta_pkg::ENTRIES];
    logic [15:0] r_port_mem [nta_pkg::ENTRIES];
    logic [47:0] r_res_mem  [nta_pkg::ENTRIES];
    logic [31:0] r_seen_mem [nta_pkg::ENTRIES];

    logic [nta_pkg::ENTRIES-1:0] r_valid;
    nta_pkg::t_in_item           r_item;
    logic [31:0]                 r_time;
    logic [15:0]                 r_timeout;

    logic [nta_pkg::IDX_W-1:0] r_idx;
    logic [nta_pkg::IDX_W-1:0] r_cmp_idx;
    logic                      r_cmp_vld;
    logic [31:0]               r_key_rd;
    logic [15:0]               r_port_rd;
    logic [31:0]               r_seen_rd;

    logic                      r_found;
    logic [nta_pkg::IDX_W-1:0] r_hit_idx;
    logic [15:0]               r_hit_port;
    logic                      r_free_found;
    logic [nta_pkg::IDX_W-1:0] r_free_idx;

    logic                      r_out_valid;
    nta_pkg::t_out_item        r_out_data;
    nta_pkg::t_out_item        n_out_data;

    logic                      w_cmp_entry_valid;
    logic                      w_hit;
    logic                      w_aged;
    logic [nta_pkg::IDX_W-1:0] w_slot;
    logic                      w_slot_ok;
    logic                      w_write;

    assign o_sts.in_tick   = (i_in_data.operation == nta_pkg::OP_TICK);
    assign o_sts.scan_last = (r_idx == nta_pkg::IDX_W'(nta_pkg::ENTRIES - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign w_cmp_entry_valid = r_valid[r_cmp_idx];
    assign w_hit   = w_cmp_entry_valid && (r_key_rd == r_item.ip_address);
    // Age wraps modulo 2^32 like the tick counter.
    assign w_aged  = (r_time - r_seen_rd) > 32'(r_timeout);
    assign w_slot    = r_found ? r_hit_idx : r_free_idx;
    assign w_slot_ok = r_found || r_free_found;
    assign w_write   = i_cmd.commit && (r_item.operation == nta_pkg::OP_INSERT) && w_slot_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= nta_pkg::TIMEOUT_RESET;
            r_time    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (i_cmd.commit && (r_item.operation == nta_pkg::OP_TICK)) begin
                r_time <= r_time + 32'd1;
            end
        end
    end

    // Walk counter and registered memory reads; the compare uses the read data in the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.scan) begin
                r_idx <= r_idx + nta_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_cmp_idx <= r_idx;
            r_key_rd  <= r_key_mem[r_idx];
            r_port_rd <= r_port_mem[r_idx];
            r_seen_rd <= r_seen_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_key_mem[w_slot]  <= r_item.ip_address;
            r_port_mem[w_slot] <= r_item.port;
            r_res_mem[w_slot]  <= {r_item.gpu_available, r_item.memory_available,
                                   r_item.cpu_available};
            r_seen_mem[w_slot] <= r_time;
        end
    end

    // The first match and the first free slot in index order win.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_cmp_vld) begin
            if (w_hit && !r_found) begin
                r_found <= 1'b1;
            end
            if (!w_cmp_entry_valid && !r_free_found) begin
                r_free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_vld) begin
            if (w_hit && !r_found) begin
                r_hit_idx  <= r_cmp_idx;
                r_hit_port <= r_port_rd;
            end
            if (!w_cmp_entry_valid && !r_free_found) begin
                r_free_idx <= r_cmp_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (r_cmp_vld && (r_item.operation == nta_pkg::OP_PURGE)
                    && w_cmp_entry_valid && w_aged) begin
                r_valid[r_cmp_idx] <= 1'b0;
            end
            if (w_write) begin
                r_valid[w_slot] <= 1'b1;
            end
        end
    end

    always_comb begin
        n_out_data.status     = nta_pkg::ST_FULL_OR_DONE;
        n_out_data.port_value = '0;
        case (r_item.operation)
            nta_pkg::OP_INSERT: begin
                if (r_found) begin
                    n_out_data.status = nta_pkg::ST_UPDATED;
                end else if (r_free_found) begin
                    n_out_data.status = nta_pkg::ST_INSERTED;
                end
            end
            nta_pkg::OP_LOOKUP: begin
                if (r_found) begin
                    n_out_data.status     = nta_pkg::ST_FOUND;
                    n_out_data.port_value = r_hit_port;
                end else begin
                    n_out_data.status = nta_pkg::ST_NOT_FOUND;
                end
            end
            default: n_out_data.status = nta_pkg::ST_FULL_OR_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* hw/rtl/node_table_with_aging_top.sv */
// Top level of the node table with aging: controller plus datapath.
//
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_ready      i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready    o_out_data (t_out_item)
//  cfg       input      i_cfg_we                     i_cfg_data (timeout_ticks)
//
// Insert, lookup and purge walk all ENTRIES slots through one registered
// memory read port, then pass the drain and commit states before the result.
// A tick goes straight to commit. One item is in work at a time; the next is taken
// once the result register is empty or being emptied. Reset clears the valid
// bits as a whole, so no clearing pass follows. A stalled result holds input.
module node_table_with_aging_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  nta_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output nta_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data
);

    nta_pkg::t_cmd w_cmd;
    nta_pkg::t_sts w_sts;

    nta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    nta_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* hw/rtl/nta_checker.sv */
// Port-level checker for the node table, bound to the top level.
`include "node_table_with_aging_top_macros.svh"

module nta_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input nta_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input nta_pkg::t_out_item o_out_data,
    input logic               i_cfg_we,
    input logic [15:0]        i_cfg_data
);

    // A result waiting for its transfer stays put.
    `NTA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // No new item is taken while the result register stays full.
    `NTA_ASSERT_NOW(a_no_accept_when_blocked, o_out_valid && !i_out_ready, !o_in_ready)

    // Only one item is in work: ready drops right after a transfer in.
    `NTA_ASSERT_NEXT(a_single_item, i_in_valid && o_in_ready, !o_in_ready)

    // A port value only comes with a lookup hit.
    `NTA_ASSERT_NOW(a_port_only_on_found, o_out_valid && (o_out_data.status != nta_pkg::ST_FOUND), o_out_data.port_value == 16'd0)

    // Status codes stay within the defined range.
    `NTA_ASSERT_NOW(a_status_range, o_out_valid, o_out_data.status <= nta_pkg::ST_FULL_OR_DONE)

endmodule

bind node_table_with_aging_top nta_checker u_nta_checker (.*);
